// ===== rtl/ocrc_pkg.sv =====
// Shared types and constants for the optical constants row converter.
// No dependencies.
package ocrc_pkg;

   localparam int WORD_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ABSCISSA_UNIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIELECTRIC_MODE = 2'd1;

   // abscissa unit codes
   localparam logic [1:0] UNIT_NM       = 2'd0;
   localparam logic [1:0] UNIT_EV       = 2'd1;
   localparam logic [1:0] UNIT_ANGSTROM = 2'd2;
   localparam logic [1:0] UNIT_EV_ALT   = 2'd3;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_ZERO_EV = 1'b1;

   typedef struct packed {
      logic signed [WORD_W-1:0] abscissa_value;
      logic signed [WORD_W-1:0] first_value;
      logic signed [WORD_W-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] wavelength_nm;
      logic signed [WORD_W-1:0] index_real;
      logic signed [WORD_W-1:0] index_imag;
      logic                     status;
   } rsp_type;

endpackage

// ===== rtl/ocrc_div_pipe.sv =====
// Restoring divider of a constant dividend, one quotient bit per stage.
// Standalone; sideband bits travel with each item.
module ocrc_div_pipe #(
   parameter int               NUM_W    = 64,
   parameter logic [NUM_W-1:0] DIVIDEND = '0,
   parameter int               DEN_W    = 35,
   parameter int               SIDE_W   = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff   [NUM_W];
   logic [NUM_W-1:0]  quot_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic              valid_p;
      logic [DEN_W-1:0]  den_p;
      logic [DEN_W-1:0]  rem_p;
      logic [NUM_W-1:0]  quot_p;
      logic [SIDE_W-1:0] side_p;
      logic [DEN_W:0]    trial;
      logic              fits;
      logic [DEN_W-1:0]  rem_in;

      if (s == 0) begin : g_first
         assign valid_p = in_valid;
         assign den_p   = in_den;
         assign rem_p   = '0;
         assign quot_p  = '0;
         assign side_p  = in_side;
      end else begin : g_next
         assign valid_p = valid_ff[s-1];
         assign den_p   = den_ff[s-1];
         assign rem_p   = rem_ff[s-1];
         assign quot_p  = quot_ff[s-1];
         assign side_p  = side_ff[s-1];
      end

      assign trial  = {rem_p, DIVIDEND[NUM_W-1-s]};
      assign fits   = trial >= {1'b0, den_p};
      assign rem_in = fits ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[s]  <= den_p;
            rem_ff[s]  <= rem_in;
            quot_ff[s] <= {quot_p[NUM_W-2:0], fits};
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = quot_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/ocrc_sqrt_pipe.sv =====
// Integer floor square root, one root bit per stage.
// Standalone; sideband bits travel with each item.
module ocrc_sqrt_pipe #(
   parameter int ROOT_W = 32,
   parameter int SIDE_W = 1,
   localparam int RAD_W = 2 * ROOT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [ROOT_W+1:0] rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              valid_p;
      logic [RAD_W-1:0]  rad_p;
      logic [ROOT_W+1:0] rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SIDE_W-1:0] side_p;
      logic [ROOT_W+1:0] part;
      logic [ROOT_W+1:0] trial;
      logic              fits;

      if (s == 0) begin : g_first
         assign valid_p = in_valid;
         assign rad_p   = in_rad;
         assign rem_p   = '0;
         assign root_p  = '0;
         assign side_p  = in_side;
      end else begin : g_next
         assign valid_p = valid_ff[s-1];
         assign rad_p   = rad_ff[s-1];
         assign rem_p   = rem_ff[s-1];
         assign root_p  = root_ff[s-1];
         assign side_p  = side_ff[s-1];
      end

      assign part  = {rem_p[ROOT_W-1:0], rad_p[RAD_W-1 -: 2]};
      assign trial = {root_p, 2'b01};
      assign fits  = part >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[s]  <= rad_p << 2;
            rem_ff[s]  <= fits ? part - trial : part;
            root_ff[s] <= {root_p[ROOT_W-2:0], fits};
            side_ff[s] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/optical_constants_row_converter_unit.sv =====
// Optical constants row converter, one table row per transfer.
// Channels: req_ (row in), rsp_ (converted row out), csr_ (register writes).
// Each row gives exactly one result. The abscissa becomes a wavelength in nm
// (pass through, 1239.8/x from eV, or x/10 from angstroms); the value pair
// passes through or, in dielectric mode, becomes n,k from e1,e2.
// Pipeline from req transfer to rsp_valid: three input stages,
// 64 divider stages, one select stage, 32 stages of |e| root, one stage,
// 32 stages of n/k roots, output register.
// Throughput: one row per cycle unless stalled; every stage holds one row.
// When rsp_stall is high with a result waiting, the whole pipeline freezes
// and req_stall goes high in the same cycle; nothing is dropped or repeated.
// Zero energy yields the largest positive wavelength and status set.
// Reset (synchronous) empties the pipeline and clears both registers.
// csr_ready is always high; the user must write registers only while no
// row is in flight; the block does not enforce it.
module optical_constants_row_converter_unit
   import ocrc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int            NUM_W     = 64;
   localparam int            DEN_W     = 35;
   localparam int            ROOT_W    = 32;
   localparam logic [NUM_W-1:0] DIVIDEND = NUM_W'(64'd12398 << (2 * FRAC_BITS));
   localparam logic [WORD_W-1:0] RECIP_TEN = 32'hCCCCCCCD;
   localparam logic signed [WORD_W-1:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [WORD_W-1:0] NEG_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] ang_wl;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
      logic [2*WORD_W-1:0]      sum;
      logic                     neg;
      logic                     zero;
   } div_side_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] wl;
      logic                     status;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
   } mag_side_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] wl;
      logic                     status;
      logic signed [WORD_W-1:0] a;
   } n_side_type;

   logic enable;

   logic [1:0] unit_ff;
   logic       diel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_NM;
         diel_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ABSCISSA_UNIT:   unit_ff <= csr_data[1:0];
            CSR_DIELECTRIC_MODE: diel_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // P1: input register
   logic    p1_valid_ff;
   req_type p1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_req_ff <= req_data;
      end
   end

   // P2: magnitudes, divisor, products
   logic [WORD_W-1:0]   abs_x_in, abs_a_in, abs_b_in;
   logic [DEN_W-1:0]    den_in;
   logic [2*WORD_W-1:0] ang_in, sqa_in, sqb_in;

   assign abs_x_in = p1_req_ff.abscissa_value[WORD_W-1]
                     ? ~p1_req_ff.abscissa_value + 1'b1 : p1_req_ff.abscissa_value;
   assign abs_a_in = p1_req_ff.first_value[WORD_W-1]
                     ? ~p1_req_ff.first_value + 1'b1 : p1_req_ff.first_value;
   assign abs_b_in = p1_req_ff.second_value[WORD_W-1]
                     ? ~p1_req_ff.second_value + 1'b1 : p1_req_ff.second_value;
   assign den_in   = DEN_W'({abs_x_in, 3'b000}) + DEN_W'({abs_x_in, 1'b0});
   assign ang_in   = abs_x_in * RECIP_TEN;
   assign sqa_in   = abs_a_in * abs_a_in;
   assign sqb_in   = abs_b_in * abs_b_in;

   logic                     p2_valid_ff;
   logic signed [WORD_W-1:0] p2_x_ff, p2_a_ff, p2_b_ff;
   logic                     p2_neg_ff, p2_zero_ff;
   logic [DEN_W-1:0]         p2_den_ff;
   logic [2*WORD_W-1:0]      p2_ang_ff, p2_sqa_ff, p2_sqb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (enable) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p2_x_ff    <= p1_req_ff.abscissa_value;
         p2_a_ff    <= p1_req_ff.first_value;
         p2_b_ff    <= p1_req_ff.second_value;
         p2_neg_ff  <= p1_req_ff.abscissa_value[WORD_W-1];
         p2_zero_ff <= p1_req_ff.abscissa_value == '0;
         p2_den_ff  <= den_in;
         p2_ang_ff  <= ang_in;
         p2_sqa_ff  <= sqa_in;
         p2_sqb_ff  <= sqb_in;
      end
   end

   // P3: sum of squares, angstrom result
   logic [WORD_W-1:0] ang_mag;
   div_side_type      div_side_in;

   assign ang_mag = WORD_W'(p2_ang_ff[2*WORD_W-1:35]);

   always_comb begin
      div_side_in.x      = p2_x_ff;
      div_side_in.ang_wl = p2_neg_ff ? -ang_mag : ang_mag;
      div_side_in.a      = p2_a_ff;
      div_side_in.b      = p2_b_ff;
      div_side_in.sum    = p2_sqa_ff + p2_sqb_ff;
      div_side_in.neg    = p2_neg_ff;
      div_side_in.zero   = p2_zero_ff;
   end

   logic             p3_valid_ff;
   logic [DEN_W-1:0] p3_den_ff;
   div_side_type     p3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (enable) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p3_den_ff  <= p2_den_ff;
         p3_side_ff <= div_side_in;
      end
   end

   logic         div_valid;
   logic [NUM_W-1:0] div_quot;
   div_side_type div_side;

   ocrc_div_pipe #(
      .NUM_W    (NUM_W),
      .DIVIDEND (DIVIDEND),
      .DEN_W    (DEN_W),
      .SIDE_W   ($bits(div_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p3_valid_ff),
      .in_den    (p3_den_ff),
      .in_side   (p3_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // P4: wavelength select and saturation
   logic signed [WORD_W-1:0] ev_wl;
   logic                     ev_flag;
   mag_side_type             mag_side_in;

   always_comb begin
      ev_flag = STATUS_OK;
      if (div_side.zero) begin
         ev_wl   = POS_MAX;
         ev_flag = STATUS_ZERO_EV;
      end else if (div_side.neg) begin
         ev_wl = (div_quot >= NUM_W'(64'h80000000)) ? NEG_MIN : -div_quot[WORD_W-1:0];
      end else begin
         ev_wl = (div_quot > NUM_W'(64'h7FFFFFFF)) ? POS_MAX : div_quot[WORD_W-1:0];
      end

      mag_side_in.status = STATUS_OK;
      case (unit_ff) inside
         UNIT_EV, UNIT_EV_ALT: begin
            mag_side_in.wl     = ev_wl;
            mag_side_in.status = ev_flag;
         end
         UNIT_ANGSTROM: mag_side_in.wl = div_side.ang_wl;
         default:       mag_side_in.wl = div_side.x;
      endcase
      mag_side_in.a = div_side.a;
      mag_side_in.b = div_side.b;
   end

   logic                p4_valid_ff;
   logic [2*WORD_W-1:0] p4_sum_ff;
   mag_side_type        p4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (enable) begin
         p4_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p4_sum_ff  <= div_side.sum;
         p4_side_ff <= mag_side_in;
      end
   end

   logic              mag_valid;
   logic [ROOT_W-1:0] mag_root;
   mag_side_type      mag_side;

   ocrc_sqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W ($bits(mag_side_type))
   ) u_sqrt_mag (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p4_valid_ff),
      .in_rad    (p4_sum_ff),
      .in_side   (p4_side_ff),
      .out_valid (mag_valid),
      .out_root  (mag_root),
      .out_side  (mag_side)
   );

   // P5: (|e| +- e1) scaled by half a unit
   logic signed [WORD_W+1:0] plus_in, minus_in;
   n_side_type               n_side_in;

   assign plus_in  = $signed({2'b00, mag_root}) + (WORD_W+2)'(mag_side.a);
   assign minus_in = $signed({2'b00, mag_root}) - (WORD_W+2)'(mag_side.a);

   always_comb begin
      n_side_in.wl     = mag_side.wl;
      n_side_in.status = mag_side.status;
      n_side_in.a      = mag_side.a;
   end

   logic                     p5_valid_ff;
   logic [2*ROOT_W-1:0]      p5_plus_ff, p5_minus_ff;
   n_side_type               p5_nside_ff;
   logic signed [WORD_W-1:0] p5_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (enable) begin
         p5_valid_ff <= mag_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p5_plus_ff  <= (2*ROOT_W)'(unsigned'(plus_in)) << (FRAC_BITS - 1);
         p5_minus_ff <= (2*ROOT_W)'(unsigned'(minus_in)) << (FRAC_BITS - 1);
         p5_nside_ff <= n_side_in;
         p5_b_ff     <= mag_side.b;
      end
   end

   logic                     n_valid, k_valid;
   logic [ROOT_W-1:0]        n_root, k_root;
   n_side_type               n_side;
   logic signed [WORD_W-1:0] k_b;

   ocrc_sqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W ($bits(n_side_type))
   ) u_sqrt_n (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p5_valid_ff),
      .in_rad    (p5_plus_ff),
      .in_side   (p5_nside_ff),
      .out_valid (n_valid),
      .out_root  (n_root),
      .out_side  (n_side)
   );

   ocrc_sqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W (WORD_W)
   ) u_sqrt_k (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p5_valid_ff),
      .in_rad    (p5_minus_ff),
      .in_side   (p5_b_ff),
      .out_valid (k_valid),
      .out_root  (k_root),
      .out_side  (k_b)
   );

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.wavelength_nm = n_side.wl;
      rsp_data_in.status        = n_side.status;
      rsp_data_in.index_real    = diel_ff ? n_root : n_side.a;
      rsp_data_in.index_imag    = diel_ff ? k_root : k_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= n_valid && k_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
